/* rtl/tdfm_pkg.sv */
package tdfm_pkg;

   // Store geometry
   localparam int TILE_CAPACITY = 2048;
   localparam int ROWS          = 8;
   localparam int ROW_W         = 64;
   localparam int PIX_W         = 8;
   localparam int PIX_PER_ROW   = ROW_W / PIX_W;
   localparam int IDX_W         = (TILE_CAPACITY > 1) ? $clog2(TILE_CAPACITY) : 1;
   localparam int CNT_W         = $clog2(TILE_CAPACITY + 1);

   // Field widths fixed by the interface
   localparam int LIMIT_W       = 12;
   localparam int TILE_INDEX_W  = 11;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2048;

   // Compare variants, in priority order
   localparam int NUM_VARIANTS = 4;
   localparam int VAR_PLAIN    = 0;
   localparam int VAR_MX       = 1;
   localparam int VAR_MY       = 2;
   localparam int VAR_MXY      = 3;

   typedef logic [ROW_W-1:0] row_type;
   typedef logic [ROWS-1:0][ROW_W-1:0] rows_type;
   typedef logic [NUM_VARIANTS-1:0] flip_hits_type;

   typedef struct packed {
      row_type pixel_row_0;
      row_type pixel_row_1;
      row_type pixel_row_2;
      row_type pixel_row_3;
      row_type pixel_row_4;
      row_type pixel_row_5;
      row_type pixel_row_6;
      row_type pixel_row_7;
   } req_type;

   typedef struct packed {
      logic [TILE_INDEX_W-1:0] tile_index;
      logic                    mirror_x;
      logic                    mirror_y;
      logic                    newly_added;
      logic                    store_full;
   } rsp_type;

   typedef struct packed {
      logic hit;
      logic mirror_x;
      logic mirror_y;
   } merge_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLY
   } state_type;

   // Reverse the pixel order of one row
   function automatic row_type mirror_row(input row_type v);
      row_type r;
      for (int k = 0; k < PIX_PER_ROW; k++) begin
         r[k*PIX_W +: PIX_W] = v[(PIX_PER_ROW-1-k)*PIX_W +: PIX_W];
      end
      return r;
   endfunction

endpackage

/* rtl/tdfm_ram.sv */
module tdfm_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and read with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

endmodule

/* rtl/tdfm_lane.sv */
module tdfm_lane (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [tdfm_pkg::IDX_W-1:0] addr,
   input  tdfm_pkg::row_type       row_same,
   input  tdfm_pkg::row_type       row_flip,
   output tdfm_pkg::flip_hits_type hits_ff
);
   import tdfm_pkg::*;

   row_type       rd_row;
   flip_hits_type hits_in;

   // One row of every stored tile lives in this lane
   tdfm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TILE_CAPACITY)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .addr       (addr),
      .wr_data    (row_same),
      .rd_data_ff (rd_row)
   );

   // Compare the stored row against the four orientations of the request
   always_comb begin
      hits_in            = '0;
      hits_in[VAR_PLAIN] = (rd_row == row_same);
      hits_in[VAR_MX]    = (rd_row == mirror_row(row_same));
      hits_in[VAR_MY]    = (rd_row == row_flip);
      hits_in[VAR_MXY]   = (rd_row == mirror_row(row_flip));
   end

   always_ff @(posedge clock) begin
      hits_ff <= hits_in;
   end

endmodule

/* rtl/tdfm_merge.sv */
module tdfm_merge (
   input  tdfm_pkg::flip_hits_type [tdfm_pkg::ROWS-1:0] lane_hits,
   output tdfm_pkg::merge_type                         merged
);
   import tdfm_pkg::*;

   flip_hits_type all_hits;

   // Combine lanes, then pick the first orientation that matched
   always_comb begin
      all_hits = '1;
      for (int y = 0; y < ROWS; y++) begin
         all_hits = all_hits & lane_hits[y];
      end
      merged = '0;
      if (all_hits[VAR_PLAIN]) begin
         merged.hit = 1'b1;
      end else if (all_hits[VAR_MX]) begin
         merged.hit      = 1'b1;
         merged.mirror_x = 1'b1;
      end else if (all_hits[VAR_MY]) begin
         merged.hit      = 1'b1;
         merged.mirror_y = 1'b1;
      end else if (all_hits[VAR_MXY]) begin
         merged.hit      = 1'b1;
         merged.mirror_x = 1'b1;
         merged.mirror_y = 1'b1;
      end
   end

endmodule

/* rtl/tile_dedup_with_flip_match.sv */
// Tile deduplicator with mirror matching.
// Request channel (req_valid / req_stall / req_data): one 8x8 tile of 8-bit
// pixels, eight 64-bit rows. Response channel (rsp_valid / rsp_stall /
// rsp_data): tile index, mirror flags, newly_added and store_full.
// Config channel (csr_valid / csr_ready / csr_wdata): the tile limit. The user
// must write it only while no request is in flight; the block does not
// enforce this. csr_ready is always high. A request is taken only when the
// block is idle. Eight row lanes, each with its own RAM, read one stored tile
// per cycle and compare it four ways; a merge stage reduces the lanes. A hit
// ends the scan at the first matching entry; a miss walks every held tile,
// and an empty store is not read at all. Each read passes the lane RAM
// register and the lane hit register before the merge; the serial walk of
// the store through the single RAM port of each lane sets the response time.
// The block returns to idle once the response is loaded for output.
// The response sits in an output register; while rsp_stall is high it holds,
// and the next request may already be taken and searched meanwhile.
// Reset empties the store count and sets the limit to 2048; the tile RAM is
// not cleared, since only written entries are ever read.
module tile_dedup_with_flip_match (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tdfm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tdfm_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tdfm_pkg::LIMIT_W-1:0]  csr_wdata
);
   import tdfm_pkg::*;

   state_type                       state_ff, state_in;
   logic [LIMIT_W-1:0]              limit_ff;
   logic [CNT_W-1:0]                tiles_held_ff;
   logic [CNT_W-1:0]                scan_idx_ff;
   logic                            s1_vld_ff, s2_vld_ff;
   logic [IDX_W-1:0]                s1_idx_ff, s2_idx_ff;
   rows_type                        rows_ff, rows_in;
   rsp_type                         res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rsp_type                         rsp_data_ff;

   logic                            req_accept;
   logic                            issue_en;
   logic                            hit_now;
   logic                            miss_now;
   logic                            room;
   logic                            wr_en;
   logic                            load_out;
   logic [IDX_W-1:0]                ram_addr;
   flip_hits_type [ROWS-1:0]        lane_hits;
   merge_type                       merged;

   // Unpack request rows
   always_comb begin
      rows_in    = '0;
      rows_in[0] = req_data.pixel_row_0;
      rows_in[1] = req_data.pixel_row_1;
      rows_in[2] = req_data.pixel_row_2;
      rows_in[3] = req_data.pixel_row_3;
      rows_in[4] = req_data.pixel_row_4;
      rows_in[5] = req_data.pixel_row_5;
      rows_in[6] = req_data.pixel_row_6;
      rows_in[7] = req_data.pixel_row_7;
   end

   // Row lanes
   for (genvar g = 0; g < ROWS; g++) begin : g_lane
      tdfm_lane u_lane (
         .clock    (clock),
         .wr_en    (wr_en),
         .addr     (ram_addr),
         .row_same (rows_ff[g]),
         .row_flip (rows_ff[ROWS-1-g]),
         .hits_ff  (lane_hits[g])
      );
   end

   tdfm_merge u_merge (
      .lane_hits (lane_hits),
      .merged    (merged)
   );

   // Control outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      req_accept = req_valid && !req_stall;
      hit_now   = (state_ff == ST_SCAN) && s2_vld_ff && merged.hit;
      issue_en  = (state_ff == ST_SCAN) && !hit_now && (scan_idx_ff < tiles_held_ff);
      miss_now  = (state_ff == ST_SCAN) && !issue_en && !s1_vld_ff && !s2_vld_ff;
      room      = (32'(tiles_held_ff) < 32'(limit_ff)) &&
                  (32'(tiles_held_ff) < TILE_CAPACITY);
      wr_en     = miss_now && room;
      ram_addr  = wr_en ? tiles_held_ff[IDX_W-1:0] : scan_idx_ff[IDX_W-1:0];
      load_out  = (state_ff == ST_REPLY) && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

      res_in = '0;
      if (hit_now) begin
         res_in.tile_index = TILE_INDEX_W'(s2_idx_ff);
         res_in.mirror_x   = merged.mirror_x;
         res_in.mirror_y   = merged.mirror_y;
      end else if (room) begin
         res_in.tile_index  = TILE_INDEX_W'(tiles_held_ff);
         res_in.newly_added = 1'b1;
      end else begin
         res_in.store_full = 1'b1;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit_now || miss_now) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= LIMIT_RESET;
         tiles_held_ff <= '0;
         scan_idx_ff   <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            limit_ff <= csr_wdata;
         end
         if (wr_en) begin
            tiles_held_ff <= tiles_held_ff + CNT_W'(1);
         end
         if (req_accept) begin
            scan_idx_ff <= '0;
         end else if (issue_en) begin
            scan_idx_ff <= scan_idx_ff + CNT_W'(1);
         end
         // Drop reads still in flight once a hit is found
         s1_vld_ff <= issue_en;
         s2_vld_ff <= s1_vld_ff && !hit_now;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rows_ff <= rows_in;
      end
      s1_idx_ff <= scan_idx_ff[IDX_W-1:0];
      s2_idx_ff <= s1_idx_ff;
      if (hit_now || miss_now) begin
         res_ff <= res_in;
      end
      if (load_out) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Checks
   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(tiles_held_ff) <= TILE_CAPACITY)
      else $error("tile count beyond capacity");

   a_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |-> !s1_vld_ff && !s2_vld_ff)
      else $error("compare pipeline busy outside the scan");

   a_reply_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REPLY && !(rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("response not presented");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.newly_added && rsp_data_ff.store_full) &&
         !((rsp_data_ff.newly_added || rsp_data_ff.store_full) &&
           (rsp_data_ff.mirror_x || rsp_data_ff.mirror_y)))
      else $error("inconsistent response flags");

endmodule
